// ===== rtl/mf3_pkg.sv =====
// shared types and constants of the 3x3 median filter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package mf3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int OUT_DEPTH      = 16;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int SIZE_W  = 11;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd512;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_IMAGE_WIDTH  = 1'b0;
    localparam cfg_index_t REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [8:0][PIX_W-1:0] window_t;

    // per-item control that rides along the pipeline
    typedef struct packed {
        logic   has_a;
        logic   interior;
        logic   has_b;
        logic   has_c;
        logic   frame_end;
        pix_t   pixel;
        coord_t row_a;
        coord_t col_a;
        coord_t row_c;
        coord_t col_c;
    } pipe_info_t;

    typedef struct packed {
        logic   frame_end;
        coord_t column;
        coord_t row;
        pix_t   value;
    } result_t;

endpackage

// ===== rtl/mf3_front.sv =====
// size registers, raster counters, line memory and 3x3 window
// depends on mf3_pkg
`timescale 1ns / 1ps

module mf3_front #(
    parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  mf3_pkg::cfg_index_t         cfg_index,
    input  logic [mf3_pkg::SIZE_W-1:0]  cfg_wdata,
    input  logic                        in_accept,
    input  mf3_pkg::pix_t               in_pixel,
    output logic [1:0]                  in_res_n,
    output logic                        out_valid,
    output mf3_pkg::window_t            out_window,
    output mf3_pkg::pipe_info_t         out_info
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    function automatic logic [31:0] clamp_size(input logic [mf3_pkg::SIZE_W-1:0] v,
                                               input logic [31:0] hi);
        logic [31:0] ve;
        ve = 32'(v);
        if (ve < 32'd3) return 32'd3;
        if (ve > hi) return hi;
        return ve;
    endfunction

    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    logic [31:0] col32, row32, w32, h32, c0_32, rinc32, r0_32;
    logic        wrap, c_last, r_last;
    logic [CW-1:0] c0;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    mf3_pkg::pipe_info_t info_next;

    logic                s1_valid_reg;
    logic [CW-1:0]       s1_addr_reg;
    mf3_pkg::pipe_info_t s1_info_reg;
    logic [15:0]         rd_q_reg;

    // each word holds {two rows back, one row back}
    logic [15:0] line_mem [MAX_WIDTH];

    mf3_pkg::window_t    window_reg, window_next;
    logic                out_valid_reg;
    mf3_pkg::pipe_info_t out_info_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(clamp_size(mf3_pkg::SIZE_RESET, 32'(MAX_WIDTH)));
            height_reg <= HW'(clamp_size(mf3_pkg::SIZE_RESET, 32'(MAX_HEIGHT)));
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mf3_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= WW'(clamp_size(cfg_wdata, 32'(MAX_WIDTH)));
                end
                mf3_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= HW'(clamp_size(cfg_wdata, 32'(MAX_HEIGHT)));
                end
                default: begin
                end
            endcase
        end
    end

    // position of the arriving pixel, wrapped against the current size
    always_comb begin
        col32  = 32'(col_reg);
        row32  = 32'(row_reg);
        w32    = 32'(width_reg);
        h32    = 32'(height_reg);
        wrap   = col32 >= w32;
        c0_32  = wrap ? 32'd0 : col32;
        rinc32 = wrap ? row32 + 32'd1 : row32;
        r0_32  = (rinc32 >= h32) ? 32'd0 : rinc32;
        c_last = (c0_32 + 32'd1) == w32;
        r_last = (r0_32 + 32'd1) == h32;
        c0     = CW'(c0_32);

        col_next = c_last ? '0 : CW'(c0_32 + 32'd1);
        if (c_last) begin
            row_next = r_last ? '0 : RW'(r0_32 + 32'd1);
        end else begin
            row_next = RW'(r0_32);
        end

        info_next.has_a     = (r0_32 != 32'd0) && (c0_32 != 32'd0);
        info_next.interior  = (r0_32 >= 32'd2) && (c0_32 >= 32'd2);
        info_next.has_b     = (r0_32 != 32'd0) && c_last;
        info_next.has_c     = r_last;
        info_next.frame_end = c_last;
        info_next.pixel     = in_pixel;
        info_next.row_a     = mf3_pkg::COORD_W'(r0_32 - 32'd1);
        info_next.col_a     = mf3_pkg::COORD_W'(c0_32 - 32'd1);
        info_next.row_c     = mf3_pkg::COORD_W'(r0_32);
        info_next.col_c     = mf3_pkg::COORD_W'(c0_32);

        in_res_n = 2'(info_next.has_a) + 2'(info_next.has_b) + 2'(info_next.has_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= in_accept;
            out_valid_reg <= s1_valid_reg;
            if (in_accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_addr_reg <= c0;
            s1_info_reg <= info_next;
        end
        if (s1_valid_reg) begin
            out_info_reg <= s1_info_reg;
        end
    end

    // read at accept, written back in the next cycle; the same column comes
    // back no sooner than three items on, so no forwarding is needed
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_q_reg <= line_mem[c0];
        end
        if (s1_valid_reg) begin
            line_mem[s1_addr_reg] <= {rd_q_reg[7:0], s1_info_reg.pixel};
        end
    end

    always_comb begin
        window_next    = window_reg;
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = rd_q_reg[15:8];
        window_next[3] = window_reg[4];
        window_next[4] = window_reg[5];
        window_next[5] = rd_q_reg[7:0];
        window_next[6] = window_reg[7];
        window_next[7] = window_reg[8];
        window_next[8] = s1_info_reg.pixel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (s1_valid_reg) begin
            window_reg <= window_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_window = window_reg;
    assign out_info   = out_info_reg;

endmodule

// ===== rtl/mf3_median.sv =====
// two-stage median of nine: sort each row, then combine row ranks
// depends on mf3_pkg
`timescale 1ns / 1ps

module mf3_median (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  mf3_pkg::window_t    in_window,
    input  mf3_pkg::pipe_info_t in_info,
    output logic                out_valid,
    output mf3_pkg::pix_t       out_value_a,
    output mf3_pkg::pix_t       out_border,
    output mf3_pkg::pipe_info_t out_info
);

    function automatic mf3_pkg::pix_t min2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf3_pkg::pix_t max2(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic mf3_pkg::pix_t med3(input mf3_pkg::pix_t a, input mf3_pkg::pix_t b,
                                           input mf3_pkg::pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic                sa_valid_reg;
    mf3_pkg::window_t    sorted_reg, sorted_next;
    mf3_pkg::pix_t       sa_w4_reg, sa_w5_reg;
    mf3_pkg::pipe_info_t sa_info_reg;

    logic                sb_valid_reg;
    mf3_pkg::pix_t       lo_max_reg, md_med_reg, hi_min_reg;
    mf3_pkg::pix_t       sb_w4_reg, sb_w5_reg;
    mf3_pkg::pipe_info_t sb_info_reg;

    // per row: lowest, middle, highest
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sorted_next[3*k]   = min2(min2(in_window[3*k], in_window[3*k+1]),
                                      in_window[3*k+2]);
            sorted_next[3*k+1] = med3(in_window[3*k], in_window[3*k+1], in_window[3*k+2]);
            sorted_next[3*k+2] = max2(max2(in_window[3*k], in_window[3*k+1]),
                                      in_window[3*k+2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
        end else begin
            sa_valid_reg <= in_valid;
            sb_valid_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            sorted_reg  <= sorted_next;
            sa_w4_reg   <= in_window[4];
            sa_w5_reg   <= in_window[5];
            sa_info_reg <= in_info;
        end
        if (sa_valid_reg) begin
            lo_max_reg  <= max2(max2(sorted_reg[0], sorted_reg[3]), sorted_reg[6]);
            md_med_reg  <= med3(sorted_reg[1], sorted_reg[4], sorted_reg[7]);
            hi_min_reg  <= min2(min2(sorted_reg[2], sorted_reg[5]), sorted_reg[8]);
            sb_w4_reg   <= sa_w4_reg;
            sb_w5_reg   <= sa_w5_reg;
            sb_info_reg <= sa_info_reg;
        end
    end

    assign out_valid   = sb_valid_reg;
    assign out_value_a = sb_info_reg.interior ? med3(lo_max_reg, md_med_reg, hi_min_reg)
                                              : sb_w4_reg;
    assign out_border  = sb_w5_reg;
    assign out_info    = sb_info_reg;

endmodule

// ===== rtl/mf3_out_queue.sv =====
// result queue: takes up to three results per cycle, hands out one while out_ready is high
// depends on mf3_pkg; input credit is reserved at accept time
`timescale 1ns / 1ps

module mf3_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          res_n,
    output logic                in_ready,
    input  logic                push_valid,
    input  mf3_pkg::pipe_info_t push_info,
    input  mf3_pkg::pix_t       push_value_a,
    input  mf3_pkg::pix_t       push_border,
    output logic                out_valid,
    input  logic                out_ready,
    output mf3_pkg::result_t    out_item
);

    localparam int DEPTH = mf3_pkg::OUT_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    mf3_pkg::result_t queue_mem [DEPTH];
    mf3_pkg::result_t entry [3];
    mf3_pkg::result_t res_a, res_b, res_c;

    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg, reserved_reg;
    logic [1:0]      push_n;
    logic            pop;

    always_comb begin
        res_a = '{frame_end: 1'b0, column: push_info.col_a, row: push_info.row_a,
                  value: push_value_a};
        res_b = '{frame_end: 1'b0, column: push_info.col_c, row: push_info.row_a,
                  value: push_border};
        res_c = '{frame_end: push_info.frame_end, column: push_info.col_c,
                  row: push_info.row_c, value: push_info.pixel};

        // pack present results to the front, keeping their order
        entry[0] = push_info.has_a ? res_a : (push_info.has_b ? res_b : res_c);
        entry[1] = (push_info.has_a && push_info.has_b) ? res_b : res_c;
        entry[2] = res_c;

        push_n = push_valid ? (2'(push_info.has_a) + 2'(push_info.has_b)
                               + 2'(push_info.has_c)) : 2'd0;
    end

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_item  = queue_mem[rd_ptr_reg];
    assign in_ready  = reserved_reg <= CNTW'(DEPTH - 3);

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < push_n) begin
                queue_mem[PW'(wr_ptr_reg + PW'(k))] <= entry[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            reserved_reg <= '0;
        end else begin
            wr_ptr_reg   <= wr_ptr_reg + PW'(push_n);
            rd_ptr_reg   <= rd_ptr_reg + PW'(pop);
            count_reg    <= count_reg + CNTW'(push_n) - CNTW'(pop);
            reserved_reg <= reserved_reg + CNTW'(res_n) - CNTW'(pop);
        end
    end

    a_reserved_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        reserved_reg <= CNTW'(DEPTH))
        else $error("reserved slots exceed queue depth");

    a_count_within_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= reserved_reg)
        else $error("queue holds more results than were reserved");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push_n == 2'd0 && res_n == 2'd0) |=>
            (count_reg + CNTW'(1) == $past(count_reg))
            && (reserved_reg + CNTW'(1) == $past(reserved_reg)))
        else $error("pop without push did not drain queue by one");

endmodule

// ===== rtl/median_filter_3x3_core.sv =====
// 3x3 median filter core: an accepted pixel passes the front's read and window registers,
// the median's sort and rank registers and the result queue before its first result is
// valid; one pixel accepted per cycle while the result queue has room for three more
// results. results leave one per cycle on the single output port while m_tready is high,
// so the three results of a row-end pixel leave one after another. reset is synchronous,
// active low: counters, queue, window and sizes (512 each) are cleared; the line memory is not
`timescale 1ns / 1ps

module median_filter_3x3_core #(
    parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  mf3_pkg::cfg_index_t         cfg_index,
    input  logic [mf3_pkg::SIZE_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] pixel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [7:0] value, [17:8] row, [27:18] column
    output logic                        m_tlast    // frame_end
);

    logic                s_accept;
    logic [1:0]          res_n;
    logic                win_valid;
    mf3_pkg::window_t    win;
    mf3_pkg::pipe_info_t win_info;
    logic                med_valid;
    mf3_pkg::pix_t       med_value_a, med_border;
    mf3_pkg::pipe_info_t med_info;
    mf3_pkg::result_t    out_item;

    assign s_accept = s_tvalid && s_tready;

    mf3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_accept  (s_accept),
        .in_pixel   (s_tdata),
        .in_res_n   (res_n),
        .out_valid  (win_valid),
        .out_window (win),
        .out_info   (win_info)
    );

    mf3_median u_median (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (win_valid),
        .in_window   (win),
        .in_info     (win_info),
        .out_valid   (med_valid),
        .out_value_a (med_value_a),
        .out_border  (med_border),
        .out_info    (med_info)
    );

    mf3_out_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .res_n        (s_accept ? res_n : 2'd0),
        .in_ready     (s_tready),
        .push_valid   (med_valid),
        .push_info    (med_info),
        .push_value_a (med_value_a),
        .push_border  (med_border),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_item     (out_item)
    );

    assign m_tdata = {4'b0000, out_item.column, out_item.row, out_item.value};
    assign m_tlast = out_item.frame_end;

endmodule

// ===== tb/tb_median_filter_3x3_core.sv =====
// self-checking testbench for median_filter_3x3_core: streams pixel frames of
// several sizes through the core and compares every filtered item in order.
// depends on mf3_pkg and median_filter_3x3_core
`timescale 1ns / 1ps

module tb_median_filter_3x3_core;

    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 90;
    localparam int SHORT_RUN    = 24;

    typedef enum int {PIX_ANY, PIX_NARROW, PIX_RAILS} pix_style_e;
    typedef enum int {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_e;

    // expected filtered pixels, worked out from the accepted input stream
    class median_scoreboard;
        int unsigned width_reg  = 512;
        int unsigned height_reg = 512;
        bit [mf3_pkg::PIX_W-1:0] line_up2 [mf3_pkg::DEF_MAX_WIDTH];
        bit [mf3_pkg::PIX_W-1:0] line_up1 [mf3_pkg::DEF_MAX_WIDTH];
        bit [mf3_pkg::PIX_W-1:0] nbhd [3][3];   // [line][column], line 0 oldest, column 2 newest
        int unsigned row_cnt;
        int unsigned col_cnt;
        int unsigned checked;
        int unsigned errors;
        mf3_pkg::result_t filtered_q [$];

        function int unsigned clamped(int unsigned v, int unsigned hi);
            if (v < 3) return 3;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned used_width();
            return clamped(width_reg, mf3_pkg::DEF_MAX_WIDTH);
        endfunction

        function int unsigned used_height();
            return clamped(height_reg, mf3_pkg::DEF_MAX_HEIGHT);
        endfunction

        function bit at_frame_start();
            return row_cnt == 0 && col_cnt == 0;
        endfunction

        function int unsigned pending();
            return filtered_q.size();
        endfunction

        function void set_size(mf3_pkg::cfg_index_t idx, logic [mf3_pkg::SIZE_W-1:0] v);
            if (idx == mf3_pkg::REG_IMAGE_WIDTH) begin
                width_reg = v;
            end else begin
                height_reg = v;
            end
        endfunction

        // value of rank 4 among the nine window pixels
        function bit [mf3_pkg::PIX_W-1:0] median9();
            bit [mf3_pkg::PIX_W-1:0] v [9];
            int lt;
            int le;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    v[3*i+j] = nbhd[i][j];
            for (int i = 0; i < 9; i++) begin
                lt = 0;
                le = 0;
                for (int j = 0; j < 9; j++) begin
                    if (v[j] < v[i]) lt++;
                    if (v[j] <= v[i]) le++;
                end
                if (lt <= 4 && le >= 5) return v[i];
            end
            return v[4];
        endfunction

        function void queue_filtered(bit [mf3_pkg::PIX_W-1:0] v, int unsigned r,
                                     int unsigned c, bit fe);
            mf3_pkg::result_t res;
            res.value     = v;
            res.row       = mf3_pkg::coord_t'(r);
            res.column    = mf3_pkg::coord_t'(c);
            res.frame_end = fe;
            filtered_q.insert(filtered_q.size(), res);
        endfunction

        function void take_pixel(mf3_pkg::pix_t px);
            int unsigned w;
            int unsigned h;
            bit [mf3_pkg::PIX_W-1:0] top;
            bit [mf3_pkg::PIX_W-1:0] mid;
            w = used_width();
            h = used_height();
            // counters left beyond a shrunken size wrap before the pixel is taken
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
            if (row_cnt >= h) row_cnt = 0;
            top = line_up2[col_cnt];
            mid = line_up1[col_cnt];
            for (int i = 0; i < 3; i++) begin
                nbhd[i][0] = nbhd[i][1];
                nbhd[i][1] = nbhd[i][2];
            end
            nbhd[0][2] = top;
            nbhd[1][2] = mid;
            nbhd[2][2] = px;
            line_up2[col_cnt] = mid;
            line_up1[col_cnt] = px;

            if (row_cnt >= 1 && col_cnt >= 1)
                queue_filtered((row_cnt >= 2 && col_cnt >= 2) ? median9() : nbhd[1][1],
                               row_cnt - 1, col_cnt - 1, 1'b0);
            // right border of the row above
            if (row_cnt >= 1 && col_cnt == w - 1)
                queue_filtered(nbhd[1][2], row_cnt - 1, col_cnt, 1'b0);
            // last row passes straight through
            if (row_cnt == h - 1)
                queue_filtered(px, row_cnt, col_cnt, col_cnt == w - 1);

            col_cnt++;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= h) row_cnt = 0;
            end
        endfunction

        function void check_filtered(logic [31:0] data, logic last);
            mf3_pkg::result_t want;
            checked++;
            if (filtered_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("item %0d unexpected: value %0d row %0d column %0d last %b",
                             checked, data[7:0], data[17:8], data[27:18], last);
                return;
            end
            want = filtered_q.pop_front();
            if (data[7:0] !== want.value || data[17:8] !== want.row ||
                data[27:18] !== want.column || last !== want.frame_end ||
                data[31:28] !== 4'b0) begin
                errors++;
                if (errors <= 10)
                    $display({"item %0d mismatch: expected value %0d row %0d column %0d ",
                              "last %b, got value %0d row %0d column %0d last %b pad %h"},
                             checked, want.value, want.row, want.column, want.frame_end,
                             data[7:0], data[17:8], data[27:18], last, data[31:28]);
            end
        endfunction
    endclass

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    mf3_pkg::cfg_index_t         cfg_index = mf3_pkg::REG_IMAGE_WIDTH;
    logic [mf3_pkg::SIZE_W-1:0]  cfg_wdata = '0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata   = '0;   // [7:0] pixel
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [31:0]                 m_tdata;          // [7:0] value, [17:8] row, [27:18] column
    logic                        m_tlast;          // frame_end

    median_scoreboard sb = new;

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned hold_requests;
    int unsigned holds_seen;
    int unsigned hold_left;
    int unsigned pixels_sent;

    mf3_pkg::pix_t corner_pix [12] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'hFE,
                                       8'h80, 8'h7F, 8'h0F, 8'hF0, 8'h33, 8'hCC};
    mf3_pkg::pix_t tie_pix [9] = '{8'd7, 8'd7, 8'd7, 8'd0, 8'd255, 8'd7, 8'd255, 8'd0,
                                   8'd0};

    median_filter_3x3_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // result side ready, with random stalls and an occasional long hold-off
    always @(posedge aclk) begin
        if (holds_seen != hold_requests) begin
            holds_seen <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_filtered(m_tdata, m_tlast);
    end

    function automatic mf3_pkg::pix_t pick_pixel(pix_style_e style);
        case (style)
            PIX_NARROW: return mf3_pkg::pix_t'(8'd120 + $urandom_range(3));
            PIX_RAILS: begin
                if ($urandom_range(3) == 0) return mf3_pkg::pix_t'($urandom_range(255));
                return $urandom_range(1) ? 8'hFF : 8'h00;
            end
            default: return mf3_pkg::pix_t'($urandom_range(255));
        endcase
    endfunction

    task automatic set_flow(flow_e f);
        case (f)
            FLOW_SRC_GAPS: begin
                idle_pct = 52;
                stall_pct <= 0;
            end
            FLOW_SINK_STALLS: begin
                idle_pct = 0;
                stall_pct <= 52;
            end
            FLOW_BOTH: begin
                idle_pct = 21;
                stall_pct <= 21;
            end
            default: begin
                idle_pct = 0;
                stall_pct <= 0;
            end
        endcase
    endtask

    task automatic send_pixel(mf3_pkg::pix_t px);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_run(int unsigned n, pix_style_e style);
        repeat (n) send_pixel(pick_pixel(style));
    endtask

    task automatic finish_frame(pix_style_e style);
        while (!sb.at_frame_start()) send_pixel(pick_pixel(style));
    endtask

    // stop offering, wait out every expected item and the pipeline behind it
    task automatic stop_and_settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sizes(logic [mf3_pkg::SIZE_W-1:0] w, logic [mf3_pkg::SIZE_W-1:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= mf3_pkg::REG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        sb.set_size(mf3_pkg::REG_IMAGE_WIDTH, w);
        cfg_index <= mf3_pkg::REG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        sb.set_size(mf3_pkg::REG_IMAGE_HEIGHT, h);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int unsigned rand_start;
        int unsigned phase;
        int unsigned n;
        int unsigned eff_w;
        int unsigned eff_h;
        logic [mf3_pkg::SIZE_W-1:0] w;
        logic [mf3_pkg::SIZE_W-1:0] h;
        pix_style_e style;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // row 0 at the reset size: no items come out yet
        set_flow(FLOW_FREE);
        foreach (corner_pix[i]) send_pixel(corner_pix[i]);
        stop_and_settle();

        // sizes below the minimum, written mid-row: wraps into row 1 of a 3x3 frame
        write_sizes(11'd0, 11'd1);
        finish_frame(PIX_RAILS);
        foreach (tie_pix[i]) send_pixel(tie_pix[i]);
        stop_and_settle();

        // widest row, clamped from the top of the register range, left mid-row
        set_flow(FLOW_SRC_GAPS);
        write_sizes(11'd2047, 11'd2);
        send_run(SHORT_RUN, PIX_ANY);
        stop_and_settle();

        // tallest frame, narrowest row: the shrink wraps into the next row
        set_flow(FLOW_SINK_STALLS);
        write_sizes(11'd3, 11'd1025);
        send_run(SHORT_RUN, PIX_NARROW);
        stop_and_settle();

        // sink holds off while the source keeps offering, then a full drain between frames
        set_flow(FLOW_FREE);
        write_sizes(11'd8, 11'd5);
        hold_requests <= hold_requests + 1;
        send_run(40, PIX_ANY);
        stop_and_settle();
        send_run(40, PIX_RAILS);
        stop_and_settle();

        rand_start = pixels_sent;
        phase = 0;
        while (pixels_sent - rand_start < RANDOM_ITEMS) begin
            set_flow(flow_e'(phase % 4));
            style = pix_style_e'($urandom_range(2));
            w = ($urandom_range(4) == 0) ? mf3_pkg::SIZE_W'($urandom_range(2))
                                         : mf3_pkg::SIZE_W'($urandom_range(12, 3));
            h = ($urandom_range(4) == 0) ? mf3_pkg::SIZE_W'($urandom_range(2))
                                         : mf3_pkg::SIZE_W'($urandom_range(6, 3));
            eff_w = (w < 3) ? 3 : w;
            eff_h = (h < 3) ? 3 : h;
            // rows only grow at a frame start, so no unwritten line entry is read
            if (eff_w > sb.used_width()) finish_frame(style);
            stop_and_settle();
            write_sizes(w, h);
            n = $urandom_range(eff_w * eff_h * 2, eff_w * 2);
            send_run(n, style);
            phase++;
        end

        stop_and_settle();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
